>>> rtl/sa24_pkg.sv
// ----------------------------------------------------------------------------
// sa24_pkg
// shared types and operation codes for the 24-operation script alu
// ----------------------------------------------------------------------------
package sa24_pkg;

    localparam int unsigned DW       = 32;
    localparam int unsigned OPW      = 8;
    localparam int unsigned IN_W     = 104;
    localparam int unsigned OUT_W    = 72;
    localparam int unsigned DIV_STEPS = DW;

    localparam logic [OPW-1:0] OP_ADD  = 8'd0;
    localparam logic [OPW-1:0] OP_SUB  = 8'd1;
    localparam logic [OPW-1:0] OP_OR   = 8'd2;
    localparam logic [OPW-1:0] OP_AND  = 8'd3;
    localparam logic [OPW-1:0] OP_XOR  = 8'd4;
    localparam logic [OPW-1:0] OP_LOR  = 8'd5;
    localparam logic [OPW-1:0] OP_LAND = 8'd6;
    localparam logic [OPW-1:0] OP_LNOT = 8'd7;
    localparam logic [OPW-1:0] OP_NOT  = 8'd8;
    localparam logic [OPW-1:0] OP_GT   = 8'd9;
    localparam logic [OPW-1:0] OP_LT   = 8'd10;
    localparam logic [OPW-1:0] OP_EQ   = 8'd11;
    localparam logic [OPW-1:0] OP_GE   = 8'd12;
    localparam logic [OPW-1:0] OP_LE   = 8'd13;
    localparam logic [OPW-1:0] OP_NE   = 8'd14;
    localparam logic [OPW-1:0] OP_MUL  = 8'd15;
    localparam logic [OPW-1:0] OP_DIV  = 8'd16;
    localparam logic [OPW-1:0] OP_SHL  = 8'd17;
    localparam logic [OPW-1:0] OP_SRA  = 8'd18;
    localparam logic [OPW-1:0] OP_MOV  = 8'd19;
    localparam logic [OPW-1:0] OP_FMUL = 8'd20;
    localparam logic [OPW-1:0] OP_FDIV = 8'd21;
    localparam logic [OPW-1:0] OP_REM  = 8'd22;
    localparam logic [OPW-1:0] OP_NEG  = 8'd23;
    localparam logic [OPW-1:0] OP_COUNT = 8'd24;

    localparam logic [DW-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [DW-1:0] SIGN_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic [DW-1:0]  a;
        logic [DW-1:0]  b;
        logic [DW-1:0]  tag;
        logic [DW-1:0]  res;
        logic           we;
        logic [47:0]    prod;
        logic           neg_q;
        logic           neg_r;
        logic [DW-1:0]  dvs;
    } side_t;

endpackage

>>> rtl/script_alu_24_ops_top.sv
// ----------------------------------------------------------------------------
// script_alu_24_ops_top
// use: requests enter on s_axis (tdata = action, operand_a, operand_b,
// dest_tag from the lowest bit up) and results leave on m_axis (tdata =
// value, write_enable, dest_out). every request gives exactly one result,
// in order. the block holds no state between requests.
// path: an accepted request reaches m_tvalid through the input register,
// which loads at the accepting edge, then one decode/multiply stage,
// 32 radix-2 divide stages and the output register. every operation takes
// the same path.
// throughput: one request per cycle while m_axis does not stall, set by the fully pipelined divider.
// stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready drops; nothing is lost or repeated. the pipeline advances
// whenever the output register is empty or being read; empty stages are
// not skipped.
// reset: aresetn low for one clock empties the pipeline; no result is
// pending afterwards.
// ----------------------------------------------------------------------------
module script_alu_24_ops_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // action, operand_a, operand_b, dest_tag
    input  logic [sa24_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // value, write_enable, dest_out, zero pad
    output logic [sa24_pkg::OUT_W-1:0] m_tdata
);
    import sa24_pkg::*;

    localparam int unsigned NS = DIV_STEPS;

    logic           en;
    logic [DW-1:0]  in_a_reg, in_b_reg, in_tag_reg;
    logic [OPW-1:0] in_op_reg;
    logic           in_vld_reg;

    side_t          st_reg [0:NS];
    logic           vld_reg [0:NS];
    logic [DW-1:0]  rem_reg [0:NS];
    logic [DW-1:0]  nq_reg [0:NS];

    side_t          s1_next;
    logic [DW-1:0]  s1_num_next;
    logic [63:0]    prod_full;
    logic [DW-1:0]  fd;
    logic [DW-1:0]  sh_l, sh_r;
    logic           slt, seq;

    logic [DW-1:0]  val_reg, dest_reg, val_next;
    logic           we_reg, out_vld_reg;
    logic [DW-1:0]  qv, rv;
    logic [15:0]    hi_fix;

    assign en = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
        if (en) begin
            in_op_reg  <= s_tdata[7:0];
            in_a_reg   <= s_tdata[39:8];
            in_b_reg   <= s_tdata[71:40];
            in_tag_reg <= s_tdata[103:72];
        end
    end

    // decode, simple ops and multiply
    always_comb begin
        fd        = $unsigned($signed(in_b_reg) >>> 8);
        sh_l      = in_a_reg << in_b_reg[4:0];
        sh_r      = $unsigned($signed(in_a_reg) >>> in_b_reg[4:0]);
        slt       = $signed(in_a_reg) < $signed(in_b_reg);
        seq       = in_a_reg == in_b_reg;
        prod_full = in_a_reg * in_b_reg;
        s1_next.op   = in_op_reg;
        s1_next.a    = in_a_reg;
        s1_next.b    = in_b_reg;
        s1_next.tag  = in_tag_reg;
        s1_next.prod = prod_full[47:0];
        s1_next.we   = in_op_reg < OP_COUNT;
        s1_next.res  = '0;
        unique case (in_op_reg)
            OP_ADD:  s1_next.res = in_a_reg + in_b_reg;
            OP_SUB:  s1_next.res = in_a_reg - in_b_reg;
            OP_OR:   s1_next.res = in_a_reg | in_b_reg;
            OP_AND:  s1_next.res = in_a_reg & in_b_reg;
            OP_XOR:  s1_next.res = in_a_reg ^ in_b_reg;
            OP_LOR:  s1_next.res = {31'd0, (in_a_reg != '0) || (in_b_reg != '0)};
            OP_LAND: s1_next.res = {31'd0, (in_a_reg != '0) && (in_b_reg != '0)};
            OP_LNOT: s1_next.res = {31'd0, in_a_reg == '0};
            OP_NOT:  s1_next.res = ~in_a_reg;
            OP_GT:   s1_next.res = {31'd0, $signed(in_b_reg) < $signed(in_a_reg)};
            OP_LT:   s1_next.res = {31'd0, slt};
            OP_EQ:   s1_next.res = {31'd0, seq};
            OP_GE:   s1_next.res = {31'd0, !slt};
            OP_LE:   s1_next.res = {31'd0, slt || seq};
            OP_NE:   s1_next.res = {31'd0, !seq};
            OP_SHL:  s1_next.res = sh_l;
            OP_SRA:  s1_next.res = sh_r;
            OP_MOV:  s1_next.res = in_a_reg;
            OP_NEG:  s1_next.res = '0 - in_a_reg;
            default: s1_next.res = '0;
        endcase
        if (in_op_reg == OP_DIV || in_op_reg == OP_REM) begin
            if (in_b_reg == '0 || (in_b_reg == ALL_ONES && in_a_reg == SIGN_BIT)) begin
                s1_next.we = 1'b0;
            end
        end
        if (in_op_reg == OP_FDIV && fd == '0) begin
            s1_next.we = 1'b0;
        end
        if (in_op_reg == OP_FDIV) begin
            s1_next.dvs   = fd[31] ? '0 - fd : fd;
            s1_next.neg_q = in_a_reg[31] ^ fd[31];
        end else begin
            s1_next.dvs   = in_b_reg[31] ? '0 - in_b_reg : in_b_reg;
            s1_next.neg_q = in_a_reg[31] ^ in_b_reg[31];
        end
        s1_next.neg_r = in_a_reg[31];
        s1_num_next   = in_a_reg[31] ? '0 - in_a_reg : in_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld_reg;
        end
        if (en) begin
            st_reg[0]  <= s1_next;
            rem_reg[0] <= '0;
            nq_reg[0]  <= s1_num_next;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          qbit;
        logic [DW-1:0] rem_next;
        always_comb begin
            trial    = {rem_reg[k], nq_reg[k][DW-1]};
            diff     = trial - {1'b0, st_reg[k].dvs};
            qbit     = !diff[DW];
            rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                st_reg[k+1]  <= st_reg[k];
                rem_reg[k+1] <= rem_next;
                nq_reg[k+1]  <= {nq_reg[k][DW-2:0], qbit};
            end
        end
    end

    // sign fixups and result select
    always_comb begin
        qv     = st_reg[NS].neg_q ? '0 - nq_reg[NS] : nq_reg[NS];
        rv     = st_reg[NS].neg_r ? '0 - rem_reg[NS] : rem_reg[NS];
        hi_fix = st_reg[NS].prod[47:32]
               - (st_reg[NS].a[31] ? st_reg[NS].b[15:0] : 16'd0)
               - (st_reg[NS].b[31] ? st_reg[NS].a[15:0] : 16'd0);
        unique case (st_reg[NS].op)
            OP_MUL:  val_next = st_reg[NS].prod[31:0];
            OP_FMUL: val_next = {hi_fix, st_reg[NS].prod[31:16]};
            OP_DIV:  val_next = qv;
            OP_FDIV: val_next = {qv[23:0], 8'd0};
            OP_REM:  val_next = rv;
            default: val_next = st_reg[NS].res;
        endcase
        if (!st_reg[NS].we) begin
            val_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[NS];
        end
        if (en) begin
            val_reg  <= val_next;
            we_reg   <= st_reg[NS].we;
            dest_reg <= st_reg[NS].tag;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, dest_reg, we_reg, val_reg};

endmodule
